/* rtl/crossed_loopback_ring_fifos_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the crossed loopback ring FIFOs
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef CROSSED_LOOPBACK_RING_FIFOS_ASSERT_SVH
`define CROSSED_LOOPBACK_RING_FIFOS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// check prop on every clock edge outside reset
`define CLRF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("clrf: assertion failed");

// check prop on every clock edge, reset included
`define CLRF_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("clrf: assertion failed");

`else

`define CLRF_ASSERT(label, clk, rst_n, prop)
`define CLRF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* rtl/clrf_pkg.sv */
// ----------------------------------------------------------------------------
// clrf_pkg
// Shared codes, defaults and controller command type for the ring FIFOs.
// ----------------------------------------------------------------------------
package clrf_pkg;

	localparam int RING_DEPTH_DEF = 256;
	localparam int PORTS_DEF      = 16;

	typedef enum logic [1:0] {
		CMD_OPEN  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_CLOSED = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// controller to datapath strobes
	typedef struct packed {
		logic capture;   // latch the accepted input word
		logic exec;      // check and update the target ring
		logic finish;    // build the result word
	} ctl_cmd_t;

endpackage

/* rtl/clrf_ram.sv */
// ----------------------------------------------------------------------------
// clrf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module clrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/clrf_dp.sv */
// ----------------------------------------------------------------------------
// clrf_dp
// Datapath: input latch, ring pointer file, byte store and result register.
// ----------------------------------------------------------------------------
module clrf_dp
	import clrf_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int PORTS      = PORTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	input  logic [15:0] s_tdata,
	input  logic [1:0]  s_tuser,
	output logic [15:0] m_tdata,
	output logic [1:0]  m_tuser
);

	localparam int PW = $clog2(RING_DEPTH);
	localparam int RW = $clog2(PORTS);
	localparam int AW = $clog2(PORTS * RING_DEPTH);

	cmd_code_t        cmd_q;
	logic [3:0]       port_q;
	logic [7:0]       data_q;
	status_t          st_q;
	logic             hit_q;

	logic [PW-1:0]    wp_q [PORTS];
	logic [PW-1:0]    rp_q [PORTS];
	logic [PORTS-1:0] open_q;

	logic [3:0]       sel_port;
	logic             sel_ok;
	logic [RW-1:0]    sel_idx;
	logic [PW-1:0]    cur_w;
	logic [PW-1:0]    cur_r;
	logic             cur_open;
	logic [PW-1:0]    w_next;
	logic [PW-1:0]    r_next;
	logic [PW:0]      diff;
	logic [PW-1:0]    cnt;
	logic [7:0]       avail;

	status_t          ex_st;
	logic             do_open;
	logic             wp_adv;
	logic             rp_adv;
	logic             ram_we;
	logic             ram_re;
	logic [AW-1:0]    ram_waddr;
	logic [AW-1:0]    ram_raddr;
	logic [7:0]       ram_rdata;

	// a write targets the partner ring, everything else the own ring
	assign sel_port = (cmd.exec && cmd_q == CMD_WRITE) ? (port_q ^ 4'd1) : port_q;
	assign sel_ok   = int'(sel_port) < PORTS;
	assign sel_idx  = RW'(sel_port);
	assign cur_w    = wp_q[sel_idx];
	assign cur_r    = rp_q[sel_idx];
	assign cur_open = sel_ok && open_q[sel_idx];
	assign w_next   = (cur_w == PW'(RING_DEPTH - 1)) ? '0 : cur_w + PW'(1);
	assign r_next   = (cur_r == PW'(RING_DEPTH - 1)) ? '0 : cur_r + PW'(1);

	assign diff  = (cur_w >= cur_r) ? ({1'b0, cur_w} - {1'b0, cur_r})
	                                : ({1'b0, cur_w} + (PW+1)'(RING_DEPTH) - {1'b0, cur_r});
	assign cnt   = diff[PW-1:0];
	assign avail = !cur_open ? 8'd0 : ((32'(cnt) > 255) ? 8'hFF : 8'(cnt));

	assign ram_waddr = AW'(sel_idx) * AW'(RING_DEPTH) + AW'(cur_w);
	assign ram_raddr = AW'(sel_idx) * AW'(RING_DEPTH) + AW'(cur_r);

	always_comb begin
		ex_st   = ST_OK;
		do_open = 1'b0;
		wp_adv  = 1'b0;
		rp_adv  = 1'b0;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		if (cmd.exec) begin
			case (cmd_q)
				CMD_OPEN: begin
					if (sel_ok) begin
						do_open = 1'b1;
					end else begin
						ex_st = ST_CLOSED;
					end
				end
				CMD_WRITE: begin
					if (!cur_open) begin
						ex_st = ST_CLOSED;
					end else if (w_next == cur_r) begin
						ex_st = ST_FULL;
					end else begin
						ram_we = 1'b1;
						wp_adv = 1'b1;
					end
				end
				CMD_READ: begin
					if (!cur_open) begin
						ex_st = ST_CLOSED;
					end else if (cur_w == cur_r) begin
						ex_st = ST_EMPTY;
					end else begin
						ram_re = 1'b1;
						rp_adv = 1'b1;
					end
				end
				CMD_QUERY: begin
					if (!cur_open) begin
						ex_st = ST_CLOSED;
					end
				end
				default: begin
					ex_st = ST_CLOSED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORTS; i++) begin
				wp_q[i] <= '0;
				rp_q[i] <= '0;
			end
			open_q <= '0;
		end else begin
			if (do_open) begin
				wp_q[sel_idx]   <= '0;
				rp_q[sel_idx]   <= '0;
				open_q[sel_idx] <= 1'b1;
			end
			if (wp_adv) begin
				wp_q[sel_idx] <= w_next;
			end
			if (rp_adv) begin
				rp_q[sel_idx] <= r_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= cmd_code_t'(s_tuser);
			port_q <= s_tdata[3:0];
			data_q <= s_tdata[11:4];
		end
		if (cmd.exec) begin
			st_q  <= ex_st;
			hit_q <= ram_re;
		end
		// pointers of the own ring are settled by now
		if (cmd.finish) begin
			m_tuser <= st_q;
			m_tdata <= {avail, hit_q ? ram_rdata : 8'd0};
		end
	end

	clrf_ram #(
		.WIDTH (8),
		.DEPTH (PORTS * RING_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (data_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

/* rtl/clrf_ctrl.sv */
// ----------------------------------------------------------------------------
// clrf_ctrl
// Sequencer: accept a word, execute it, then present the result word.
// ----------------------------------------------------------------------------
`include "crossed_loopback_ring_fifos_assert.svh"

module clrf_ctrl
	import clrf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	// take a new word while idle, once the result slot is free or being emptied
	assign s_tready    = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign cmd.capture = s_tvalid && s_tready;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.finish  = (state_q == ST_FIN);
	assign m_tvalid    = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					m_tvalid_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CLRF_ASSERT(a_one_strobe, clk, arst_n, $onehot0(cmd))
	`CLRF_ASSERT(a_fin_slot_free, clk, arst_n, (state_q == ST_FIN) |-> !m_tvalid_q)
	`CLRF_ASSERT(a_accept_exec, clk, arst_n, cmd.capture |=> cmd.exec)
	`CLRF_ASSERT(a_exec_finish, clk, arst_n, cmd.exec |=> (cmd.finish && !m_tvalid_q))

endmodule

/* rtl/crossed_loopback_ring_fifos.sv */
// ----------------------------------------------------------------------------
// crossed_loopback_ring_fifos
// Paired loopback serial ports, each with its own receive ring buffer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one command word: tuser holds the command
//   (open, write, read, query), tdata holds the port and the byte to send.
//   A write on port p lands in the ring of port p^1; a read or query on p
//   works on p's own ring. Each ring holds RING_DEPTH-1 bytes.
//   The master channel returns one result word per command: tuser holds the
//   status, tdata the byte read and the bytes left in the own ring.
// Sequence:
//   An accepted command word is latched, then the pointers are checked and
//   updated and the store access is issued, then the registered read data
//   is picked up into the result register. A new command is accepted only
//   after the last result is built and while the result channel keeps up.
// Reset and stall:
//   Reset closes every ring and clears all pointers at once; the byte store
//   is not cleared. A stalled result holds in its output register and no new
//   command is accepted until it is taken.
// ----------------------------------------------------------------------------
module crossed_loopback_ring_fifos
	import clrf_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int PORTS      = PORTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // port[3:0], write_data[11:4], zero[15:12]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // read_data[7:0], available[15:8]
	output logic [1:0]  m_tuser    // status[1:0]
);

	ctl_cmd_t cmd;

	clrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	clrf_dp #(
		.RING_DEPTH (RING_DEPTH),
		.PORTS      (PORTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
